@@ design/hbk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbk_pkg: shared types and constants for the boot keyboard decoder
// Buffer sizing, transaction types for the command queue and the HID usage
// to ASCII key map.
// ----------------------------------------------------------------------------
package hbk_pkg;

  // Character buffer: ring of BUFFER_DEPTH entries, one slot kept free.
  localparam int BUFFER_DEPTH = 32;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);

  // Six key slots per boot report.
  localparam int KEY_SLOTS = 6;
  localparam int SLOT_W    = $clog2(KEY_SLOTS);

  // Command queue between front and back (power of two depth).
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SHIFT_MASK = 8'h22;  // left or right shift
  localparam logic [7:0] KEY_NONE   = 8'h00;
  localparam logic [7:0] USAGE_A    = 8'h04;
  localparam logic [7:0] USAGE_Z    = 8'h1D;
  localparam logic [7:0] USAGE_UP   = 8'h52;
  localparam logic [7:0] USAGE_DOWN = 8'h51;

  typedef logic [7:0] key_t;
  typedef logic [6:0] char_t;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                          op;
    logic  [KEY_SLOTS-1:0]        push_mask;
    char_t [KEY_SLOTS-1:0]        chars;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    char_t read_char;
    logic  char_valid;
    logic  not_empty;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_FINISH
  } back_state_e;

  // HID usage to 7-bit ASCII, US layout. Zero means unmapped.
  function automatic char_t map_key(key_t usage, logic shift);
    key_t  diff;
    char_t res;
    diff = usage - USAGE_A;
    res  = '0;
    if (usage >= USAGE_A && usage <= USAGE_Z) begin
      res = (shift ? 7'h41 : 7'h61) + diff[6:0];
    end else begin
      case (usage)
        8'h1E:      res = shift ? 7'h21 : 7'h31;
        8'h1F:      res = shift ? 7'h40 : 7'h32;
        8'h20:      res = shift ? 7'h23 : 7'h33;
        8'h21:      res = shift ? 7'h24 : 7'h34;
        8'h22:      res = shift ? 7'h25 : 7'h35;
        8'h23:      res = shift ? 7'h5E : 7'h36;
        8'h24:      res = shift ? 7'h26 : 7'h37;
        8'h25:      res = shift ? 7'h2A : 7'h38;
        8'h26:      res = shift ? 7'h28 : 7'h39;
        8'h27:      res = shift ? 7'h29 : 7'h30;
        8'h28:      res = 7'h0A;
        8'h29:      res = 7'h1B;
        8'h2A:      res = 7'h08;
        8'h2B:      res = 7'h09;
        8'h2C:      res = 7'h20;
        8'h2D:      res = shift ? 7'h5F : 7'h2D;
        8'h2E:      res = shift ? 7'h2B : 7'h3D;
        8'h2F:      res = shift ? 7'h7B : 7'h5B;
        8'h30:      res = shift ? 7'h7D : 7'h5D;
        8'h31:      res = shift ? 7'h7C : 7'h5C;
        8'h33:      res = shift ? 7'h3A : 7'h3B;
        8'h34:      res = shift ? 7'h22 : 7'h27;
        8'h35:      res = shift ? 7'h7E : 7'h60;
        8'h36:      res = shift ? 7'h3C : 7'h2C;
        8'h37:      res = shift ? 7'h3E : 7'h2E;
        8'h38:      res = shift ? 7'h3F : 7'h2F;
        USAGE_UP:   res = 7'h01;
        USAGE_DOWN: res = 7'h02;
        default:    res = '0;
      endcase
    end
    return res;
  endfunction

endpackage

@@ design/hbk_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbk_front: transaction intake and key classification
// Compares each key slot with the previous report, maps new presses to ASCII
// and hands one command per transaction to the queue.
// ----------------------------------------------------------------------------
module hbk_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      operation_i,
  input  logic [7:0]                                modifiers_i,
  input  hbk_pkg::key_t [hbk_pkg::KEY_SLOTS-1:0]    keys_i,
  input  hbk_pkg::queue_status_t                    q_status_i,
  output logic                                      push_o,
  output hbk_pkg::cmd_t                             cmd_o
);
  import hbk_pkg::*;

  key_t             prev_keys_q [KEY_SLOTS];
  logic             awaiting_q;
  logic             shift;
  logic [KEY_SLOTS-1:0] held;
  char_t            ch [KEY_SLOTS];

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    shift     = |(modifiers_i & SHIFT_MASK);
    held      = '0;
    cmd_o.op  = op_e'(operation_i);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      for (int j = 0; j < KEY_SLOTS; j++) begin
        held[i] = held[i] | (prev_keys_q[j] == keys_i[i]);
      end
      ch[i]              = map_key(keys_i[i], shift);
      cmd_o.chars[i]     = ch[i];
      cmd_o.push_mask[i] = (keys_i[i] != KEY_NONE) && !held[i] &&
                           (ch[i] != '0) && !awaiting_q;
    end
  end

  // Every report, the first included, becomes the previous report.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b1;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys_q[i] <= KEY_NONE;
      end
    end else if (push_o && operation_i == OP_REPORT) begin
      awaiting_q <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys_q[i] <= keys_i[i];
      end
    end
  end

endmodule

@@ design/hbk_cmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbk_cmd_queue: short command queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module hbk_cmd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  hbk_pkg::cmd_t          cmd_i,
  input  logic                   pop_i,
  output hbk_pkg::cmd_t          head_o,
  output hbk_pkg::queue_status_t status_o
);
  import hbk_pkg::*;

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_q;
  logic [QIDX_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] count_d;

  assign head_o         = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QIDX_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ design/hbk_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbk_back: character buffer and result stage
// Pushes a report's new characters one slot per cycle, serves reads from the
// ring buffer and holds the result register towards the output channel.
// ----------------------------------------------------------------------------
module hbk_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hbk_pkg::cmd_t          head_i,
  input  hbk_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output hbk_pkg::result_t       result_o
);
  import hbk_pkg::*;

  back_state_e       state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  cmd_t              cmd_q;
  logic [PTR_W-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [PTR_W-1:0]  rp_next, wp_next;
  char_t             mem [BUFFER_DEPTH];
  char_t             rd_data_q;
  logic              out_valid_q, out_valid_d;
  result_t           result_q, result_d;
  logic              full, nonempty, out_free, do_push, out_load;

  assign rp_next  = (rp_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
  assign wp_next  = (wp_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
  assign full     = (wp_next == rp_q);
  assign nonempty = (rp_q != wp_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = (head_i.op == OP_READ) ? ST_READ : ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (slot_q == SLOT_W'(KEY_SLOTS - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_READ, ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    pop_o    = 1'b0;
    do_push  = 1'b0;
    out_load = 1'b0;
    slot_d   = slot_q;
    rp_d     = rp_q;
    wp_d     = wp_q;
    result_d = result_q;
    case (state_q)
      ST_IDLE: begin
        pop_o  = !q_status_i.empty;
        slot_d = '0;
      end
      ST_PUSH: begin
        do_push = cmd_q.push_mask[slot_q] && !full;
        slot_d  = slot_q + SLOT_W'(1);
        if (do_push) begin
          wp_d = wp_next;
        end
      end
      ST_READ: begin
        out_load           = out_free;
        result_d.read_char = nonempty ? rd_data_q : '0;
        result_d.char_valid = nonempty;
        result_d.not_empty = nonempty && (rp_next != wp_q);
        if (out_free && nonempty) begin
          rp_d = rp_next;
        end
      end
      ST_FINISH: begin
        out_load            = out_free;
        result_d.read_char  = '0;
        result_d.char_valid = 1'b0;
        result_d.not_empty  = nonempty;
      end
      default: ;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (out_load) begin
      result_q <= result_d;
    end
  end

  // Character store: one write port, one registered read at the read pointer.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wp_q] <= cmd_q.chars[slot_q];
    end
    rd_data_q <= mem[rp_q];
  end

endmodule

@@ design/hid_boot_keyboard_to_ascii_fifo_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_boot_keyboard_to_ascii_fifo_top: HID boot keyboard to ASCII buffer
// Decodes boot keyboard reports into characters held in a ring buffer and
// returns one result per transaction (reads pop a character).
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o    | operation, modifiers, key_code_0..5
//  out     | out_valid_o / out_stall_i  | read_char, char_valid,
//          |                            | buffer_not_empty
//
// A report passes through the back end as a queue pop, the six key slots in
// turn and the result; a read as a pop with the buffer read, then the result.
// The front takes a transaction every cycle until the two-entry queue fills.
// Reset is asynchronous and active low; the buffer needs no clearing pass.
// A stall on the output holds the result register and in turn the back end;
// the queue lets the front keep accepting meanwhile.
//
module hid_boot_keyboard_to_ascii_fifo_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] modifiers_i,
  input  logic [7:0] key_code_0_i,
  input  logic [7:0] key_code_1_i,
  input  logic [7:0] key_code_2_i,
  input  logic [7:0] key_code_3_i,
  input  logic [7:0] key_code_4_i,
  input  logic [7:0] key_code_5_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] read_char_o,
  output logic       char_valid_o,
  output logic       buffer_not_empty_o
);
  import hbk_pkg::*;

  key_t [KEY_SLOTS-1:0] keys;
  queue_status_t        q_status;
  cmd_t                 push_cmd;
  cmd_t                 head_cmd;
  logic                 push;
  logic                 pop;
  result_t              result;

  assign keys = {key_code_5_i, key_code_4_i, key_code_3_i,
                 key_code_2_i, key_code_1_i, key_code_0_i};

  // Front: accept, compare against the previous report, map to ASCII.
  hbk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .modifiers_i (modifiers_i),
    .keys_i      (keys),
    .q_status_i  (q_status),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Decoupling queue: front and back stall independently.
  hbk_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .head_o   (head_cmd),
    .status_o (q_status)
  );

  // Back: buffer pushes and pops, result register.
  hbk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign read_char_o        = result.read_char;
  assign char_valid_o       = result.char_valid;
  assign buffer_not_empty_o = result.not_empty;

endmodule

@@ test/tb_hid_boot_keyboard_to_ascii_fifo_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hid_boot_keyboard_to_ascii_fifo_top: self-checking bench for the decoder
// Sends boot keyboard reports and read requests through the valid/stall input
// channel. A predictor of the key map and the character ring gives one
// expected result per transaction, and each output transaction is checked
// field by field. Directed reports come first, then random typing sessions,
// read bursts and noise, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_hid_boot_keyboard_to_ascii_fifo_top;
  import hbk_pkg::*;

  // Usage codes the key map is built around (letters and arrows from hbk_pkg).
  localparam key_t USAGE_1      = 8'h1E;
  localparam key_t USAGE_0      = 8'h27;
  localparam key_t USAGE_ENTER  = 8'h28;
  localparam key_t USAGE_ESC    = 8'h29;
  localparam key_t USAGE_BSPACE = 8'h2A;
  localparam key_t USAGE_TAB    = 8'h2B;
  localparam key_t USAGE_SPACE  = 8'h2C;
  localparam key_t USAGE_MINUS  = 8'h2D;
  localparam key_t USAGE_NONUS  = 8'h32;  // non-US hash: no character
  localparam key_t USAGE_SLASH  = 8'h38;
  localparam key_t USAGE_F1     = 8'h3A;
  localparam key_t USAGE_LCTRL  = 8'hE0;

  localparam logic [7:0] MOD_NONE   = 8'h00;
  localparam logic [7:0] MOD_LSHIFT = 8'h02;
  localparam logic [7:0] MOD_RSHIFT = 8'h20;

  localparam int RANDOM_ITEMS = 1400;
  localparam int LONG_HOLD    = 250;  // receiver hold-off, in cycles

  // One pending input transaction; a marker entry is not sent, it makes the
  // sender wait until every expected result has arrived.
  typedef struct packed {
    logic                      marker;
    op_e                       op;
    logic [7:0]                mods;
    logic [KEY_SLOTS-1:0][7:0] keys;
  } kbd_item_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic       operation_i  = 1'b0;
  logic [7:0] modifiers_i  = '0;
  logic [7:0] key_code_0_i = '0;
  logic [7:0] key_code_1_i = '0;
  logic [7:0] key_code_2_i = '0;
  logic [7:0] key_code_3_i = '0;
  logic [7:0] key_code_4_i = '0;
  logic [7:0] key_code_5_i = '0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [6:0] read_char_o;
  logic       char_valid_o;
  logic       buffer_not_empty_o;

  hid_boot_keyboard_to_ascii_fifo_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .modifiers_i        (modifiers_i),
    .key_code_0_i       (key_code_0_i),
    .key_code_1_i       (key_code_1_i),
    .key_code_2_i       (key_code_2_i),
    .key_code_3_i       (key_code_3_i),
    .key_code_4_i       (key_code_4_i),
    .key_code_5_i       (key_code_5_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_char_o        (read_char_o),
    .char_valid_o       (char_valid_o),
    .buffer_not_empty_o (buffer_not_empty_o)
  );

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the buffered characters, the key slots of the last
  // report and whether the next report is the first since reset.
  // --------------------------------------------------------------------------
  kbd_item_t pending_q[$];
  result_t   expected_q[$];
  char_t     ring_q[$];
  key_t      held_keys[KEY_SLOTS];
  bit        first_report = 1'b1;

  string digits_plain = "1234567890";
  string digits_shift = "!@#$%^&*()";
  // usages 0x2D..0x38; the blank sits on the non-US hash, which is unmapped
  string punct_plain  = "-=[]\\ ;'`,./";
  string punct_shift  = "_+{}| :\"~<>?";

  int error_cnt    = 0;
  int reports_sent = 0;
  int reads_sent   = 0;
  int chars_popped = 0;
  int empty_reads  = 0;
  int pushes_lost  = 0;
  int results_seen = 0;

  // US layout, zero for anything without a character
  function automatic char_t usage_to_ascii(key_t usage, logic shift);
    char_t c;
    int    idx;
    c = '0;
    if (usage >= USAGE_A && usage <= USAGE_Z) begin
      idx = usage - USAGE_A;
      c   = char_t'((shift ? "A" : "a") + idx);
    end else if (usage >= USAGE_1 && usage <= USAGE_0) begin
      idx = usage - USAGE_1;
      c   = char_t'(shift ? digits_shift[idx] : digits_plain[idx]);
    end else if (usage >= USAGE_MINUS && usage <= USAGE_SLASH && usage != USAGE_NONUS) begin
      idx = usage - USAGE_MINUS;
      c   = char_t'(shift ? punct_shift[idx] : punct_plain[idx]);
    end else begin
      case (usage)
        USAGE_ENTER:  c = 7'h0A;
        USAGE_ESC:    c = 7'h1B;
        USAGE_BSPACE: c = 7'h08;
        USAGE_TAB:    c = 7'h09;
        USAGE_SPACE:  c = 7'h20;
        USAGE_UP:     c = 7'h01;
        USAGE_DOWN:   c = 7'h02;
        default:      c = '0;
      endcase
    end
    return c;
  endfunction

  // Applies one accepted transaction to the predictor, returns its result.
  function automatic result_t decode_transaction(kbd_item_t it);
    result_t r;
    logic    shift;
    key_t    k;
    char_t   c;
    bit      was_down;
    r = '0;
    if (it.op == OP_REPORT) begin
      shift = |(it.mods & SHIFT_MASK);
      if (first_report) begin
        first_report = 1'b0;
      end else begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          k        = it.keys[i];
          was_down = 1'b0;
          for (int j = 0; j < KEY_SLOTS; j++) begin
            if (held_keys[j] == k) was_down = 1'b1;
          end
          if (k != KEY_NONE && !was_down) begin
            c = usage_to_ascii(k, shift);
            if (c != '0) begin
              if (ring_q.size() < BUFFER_DEPTH - 1) begin
                ring_q.push_back(c);
              end else begin
                pushes_lost++;
              end
            end
          end
        end
      end
      for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = it.keys[i];
    end else if (ring_q.size() > 0) begin
      r.read_char  = ring_q.pop_front();
      r.char_valid = 1'b1;
      chars_popped++;
    end else begin
      empty_reads++;
    end
    r.not_empty = (ring_q.size() != 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h", $time, results_seen, what,
             got, want);
    error_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  logic [KEY_SLOTS-1:0][7:0] gen_prev = '0;  // keys of the last queued report

  task automatic add_report(input logic [7:0] mods, input logic [KEY_SLOTS-1:0][7:0] keys);
    kbd_item_t it;
    it.marker = 1'b0;
    it.op     = OP_REPORT;
    it.mods   = mods;
    it.keys   = keys;
    gen_prev  = keys;
    pending_q.push_back(it);
  endtask

  // Read fields other than the operation are don't-care: fill them with noise.
  task automatic add_read();
    kbd_item_t it;
    it.marker = 1'b0;
    it.op     = OP_READ;
    it.mods   = 8'($urandom);
    it.keys   = {$urandom, 16'($urandom)};
    pending_q.push_back(it);
  endtask

  task automatic add_pause();
    kbd_item_t it;
    it        = '0;
    it.marker = 1'b1;
    pending_q.push_back(it);
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of transactions with random gaps; payload held while
  // stalled. Prediction is done at the accepting edge.
  // --------------------------------------------------------------------------
  kbd_item_t drv_item;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(decode_transaction(drv_item));
        if (drv_item.op == OP_REPORT) reports_sent++;
        else reads_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (pending_q.size() > 0 && pending_q[0].marker) begin
          // hold off until the block has handed back everything
          in_valid_i <= 1'b0;
          if (expected_q.size() == 0) void'(pending_q.pop_front());
        end else if (pending_q.size() > 0) begin
          drv_item = pending_q.pop_front();
          in_valid_i   <= 1'b1;
          operation_i  <= drv_item.op;
          modifiers_i  <= drv_item.mods;
          key_code_0_i <= drv_item.keys[0];
          key_code_1_i <= drv_item.keys[1];
          key_code_2_i <= drv_item.keys[2];
          key_code_3_i <= drv_item.keys[3];
          key_code_4_i <= drv_item.keys[4];
          key_code_5_i <= drv_item.keys[5];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              9:       gap_left = $urandom_range(10, 30);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switches between modes (none, light, toggling,
  // heavy); twice it applies the LONG_HOLD hold-off so the block backs up.
  // --------------------------------------------------------------------------
  int rx_mode    = 0;
  int mode_left  = 0;
  int hold_left  = 0;
  int holds_done = 0;
  int rx_count   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) rx_count++;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if ((holds_done == 0 && rx_count >= 120) ||
                   (holds_done == 1 && rx_count >= 800)) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          1:       out_stall_i <= ($urandom_range(0, 99) < 30);
          2:       out_stall_i <= ~out_stall_i;
          3:       out_stall_i <= ($urandom_range(0, 99) < 70);
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction, read_char", read_char_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (read_char_o !== want.read_char)
          report_mismatch("read_char", read_char_o, want.read_char);
        if (char_valid_o !== want.char_valid)
          report_mismatch("char_valid", char_valid_o, want.char_valid);
        if (buffer_not_empty_o !== want.not_empty)
          report_mismatch("buffer_not_empty", buffer_not_empty_o, want.not_empty);
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Run limit, well beyond the slowest legal run.
  // --------------------------------------------------------------------------
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("tb_hid_boot_keyboard_to_ascii_fifo_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int                        queued;
    int                        pick;
    logic [7:0]                mods;
    logic [KEY_SLOTS-1:0][7:0] keys;
    bit                        paused_mid;

    for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = KEY_NONE;

    // Directed part. Keys are listed slot 5 first.
    add_read();                                                  // empty buffer
    add_report(MOD_NONE, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, USAGE_A});  // stored only
    add_report(MOD_NONE, {USAGE_UP, USAGE_NONUS, USAGE_ENTER, USAGE_1, 8'h05, USAGE_A});
    add_report(MOD_LSHIFT, {USAGE_ESC, USAGE_DOWN, USAGE_SLASH, USAGE_MINUS, USAGE_0,
                            USAGE_Z});
    add_report(MOD_RSHIFT, {8'h31, 8'h35, 8'h33, USAGE_SPACE, USAGE_TAB, USAGE_BSPACE});
    // every modifier bit but the two shifts; one letter among unmapped and top-bit codes
    add_report(~SHIFT_MASK, {8'h07, 8'h00, USAGE_LCTRL, USAGE_F1, 8'h80, 8'hFF});
    add_report(8'hFF, {8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h10});  // same key twice
    // fill the buffer, then push into a full one
    for (int r = 0; r < 3; r++) begin
      add_report(MOD_NONE, '0);
      add_report(MOD_NONE, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, USAGE_A});
    end
    for (int r = 0; r < 10; r++) add_read();
    add_pause();

    // Random part: typing sessions, read bursts and some noise.
    queued     = 0;
    paused_mid = 1'b0;
    while (queued < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        for (int r = $urandom_range(1, 8); r > 0; r--) begin
          add_read();
          queued++;
        end
      end else if (pick < 88) begin
        case ($urandom_range(0, 5))
          0:       mods = 8'($urandom);
          1:       mods = MOD_LSHIFT;
          2:       mods = MOD_RSHIFT;
          3:       mods = SHIFT_MASK;
          default: mods = MOD_NONE;
        endcase
        for (int i = 0; i < KEY_SLOTS; i++) begin
          case ($urandom_range(0, 9))
            0, 1, 2: keys[i] = KEY_NONE;
            3:       keys[i] = gen_prev[i];
            4:       keys[i] = gen_prev[$urandom_range(0, KEY_SLOTS - 1)];
            9:       keys[i] = 8'($urandom);
            default: keys[i] = ($urandom_range(0, 15) == 0) ?
                               ($urandom_range(0, 1) ? USAGE_UP : USAGE_DOWN) :
                               key_t'($urandom_range(USAGE_A, USAGE_SLASH));
          endcase
        end
        add_report(mods, keys);
        queued++;
        if ($urandom_range(0, 2) == 0) begin
          add_report($urandom_range(0, 1) ? MOD_NONE : 8'($urandom), '0);
          queued++;
        end
      end else begin
        // noise: any operation, any bytes
        if ($urandom_range(0, 1)) begin
          add_report(8'($urandom), {$urandom, 16'($urandom)});
        end else begin
          add_read();
        end
        queued++;
      end
      if (!paused_mid && queued >= RANDOM_ITEMS / 2) begin
        add_pause();
        paused_mid = 1'b1;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("covered %0d reports and %0d reads: %0d characters popped, %0d empty reads,",
             reports_sent, reads_sent, chars_popped, empty_reads);
    $display("%0d pushes dropped on a full buffer, %0d results checked",
             pushes_lost, results_seen);
    if (error_cnt == 0) begin
      $display("tb_hid_boot_keyboard_to_ascii_fifo_top: done, clean");
    end else begin
      $display("tb_hid_boot_keyboard_to_ascii_fifo_top: done, errors");
    end
    $finish;
  end

endmodule

@@ hid_boot_keyboard_to_ascii_fifo_top.f @@
design/hbk_pkg.sv
design/hbk_front.sv
design/hbk_cmd_queue.sv
design/hbk_back.sv
design/hid_boot_keyboard_to_ascii_fifo_top.sv
test/tb_hid_boot_keyboard_to_ascii_fifo_top.sv
